// ----- hdl/chd_pkg.sv -----
// Shared constants and types for the chunked body decoder.
package chd_pkg;

   // Default width of the chunk size and total byte counters
   localparam int COUNT_WIDTH_DEF = 32;
   // Entries in the queue between the front end and the parser
   localparam int QUEUE_DEPTH     = 4;
   // Width of the result length field
   localparam int LEN_WIDTH       = 32;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_DIG_0  = 8'h30;
   localparam logic [7:0] CH_DIG_9  = 8'h39;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [3:0] HEX_TEN   = 4'd10;

   // One classified body byte
   typedef struct packed {
      logic [7:0] body_byte;
      logic       restart;
      logic       is_hex;
      logic [3:0] hex_digit;
      logic       is_cr;
      logic       is_lf;
   } entry_type;

   // Head of the queue as seen by the parser
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

// ----- hdl/chd_front.sv -----
// Front end: accepts body bytes, classifies them and queues them for the parser.
module chd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_body_byte,
   input  logic              req_restart,
   output chd_pkg::head_type head,
   input  logic              pop
);
   import chd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type              queue_ff [QUEUE_DEPTH];
   logic      [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic      [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic      [CNT_W-1:0]  count_ff, count_in;
   entry_type              class_entry;
   logic                   push;
   logic                   do_pop;

   // Classify the incoming byte
   always_comb begin
      class_entry.body_byte = req_body_byte;
      class_entry.restart   = req_restart;
      class_entry.is_cr     = (req_body_byte == CH_CR);
      class_entry.is_lf     = (req_body_byte == CH_LF);
      class_entry.is_hex    = 1'b0;
      class_entry.hex_digit = '0;
      if (req_body_byte >= CH_DIG_0 && req_body_byte <= CH_DIG_9) begin
         class_entry.is_hex    = 1'b1;
         class_entry.hex_digit = 4'(req_body_byte - CH_DIG_0);
      end else if (req_body_byte >= CH_LOW_A && req_body_byte <= CH_LOW_F) begin
         class_entry.is_hex    = 1'b1;
         class_entry.hex_digit = 4'(req_body_byte - CH_LOW_A) + HEX_TEN;
      end else if (req_body_byte >= CH_UP_A && req_body_byte <= CH_UP_F) begin
         class_entry.is_hex    = 1'b1;
         class_entry.hex_digit = 4'(req_body_byte - CH_UP_A) + HEX_TEN;
      end
   end

   // Queue control
   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= class_entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

endmodule

// ----- hdl/chd_back.sv -----
// Back end: chunk parser state machine and registered result stage.
module chd_back #(
   parameter int COUNT_WIDTH = chd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  chd_pkg::head_type             head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_data_byte,
   output logic                          rsp_has_data,
   output logic                          rsp_is_last,
   output logic [chd_pkg::LEN_WIDTH-1:0] rsp_decoded_length
);
   import chd_pkg::*;

   typedef enum logic [1:0] {
      PH_SIZE,
      PH_DATA,
      PH_TRAIL,
      PH_DONE
   } phase_type;

   localparam int EXT_W = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   phase_type              phase_ff, phase_in, phase_cur;
   logic                   seen_cr_ff, seen_cr_in, seen_cr_cur;
   logic [COUNT_WIDTH-1:0] size_acc_ff, size_acc_in, size_acc_cur;
   logic [COUNT_WIDTH-1:0] left_ff, left_in, left_cur;
   logic [COUNT_WIDTH-1:0] total_ff, total_in, total_cur;
   logic                   emit;
   logic                   emit_last;
   logic [EXT_W-1:0]       total_ext;
   logic [LEN_WIDTH-1:0]   shown_len;
   logic                   advance;

   logic                   rsp_valid_ff;
   logic [7:0]             rsp_data_ff;
   logic                   rsp_has_data_ff;
   logic                   rsp_is_last_ff;
   logic [LEN_WIDTH-1:0]   rsp_len_ff;

   // Output register can take a new result
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = head.valid && advance;

   // Restart clears state before the byte is parsed
   always_comb begin
      if (head.entry.restart) begin
         phase_cur    = PH_SIZE;
         seen_cr_cur  = 1'b0;
         size_acc_cur = '0;
         left_cur     = '0;
         total_cur    = '0;
      end else begin
         phase_cur    = phase_ff;
         seen_cr_cur  = seen_cr_ff;
         size_acc_cur = size_acc_ff;
         left_cur     = left_ff;
         total_cur    = total_ff;
      end
   end

   // Parser next state
   always_comb begin
      phase_in    = phase_cur;
      seen_cr_in  = seen_cr_cur;
      size_acc_in = size_acc_cur;
      left_in     = left_cur;
      total_in    = total_cur;
      emit        = 1'b0;
      emit_last   = 1'b0;
      case (phase_cur)
         PH_DONE: begin
         end
         PH_DATA: begin
            emit = 1'b1;
            if (total_cur != CNT_MAX) begin
               total_in = total_cur + 1'b1;
            end
            if (left_cur != '0) begin
               left_in = left_cur - 1'b1;
            end
            if (left_cur <= COUNT_WIDTH'(1)) begin
               phase_in   = PH_TRAIL;
               seen_cr_in = 1'b0;
            end
         end
         PH_TRAIL: begin
            if (seen_cr_cur && head.entry.is_lf) begin
               phase_in    = PH_SIZE;
               seen_cr_in  = 1'b0;
               size_acc_in = '0;
            end else begin
               seen_cr_in = head.entry.is_cr;
            end
         end
         default: begin
            if (seen_cr_cur && head.entry.is_lf) begin
               seen_cr_in = 1'b0;
               if (size_acc_cur == '0) begin
                  phase_in  = PH_DONE;
                  emit      = 1'b1;
                  emit_last = 1'b1;
               end else begin
                  left_in     = size_acc_cur;
                  size_acc_in = '0;
                  phase_in    = PH_DATA;
               end
            end else begin
               phase_in   = PH_SIZE;
               seen_cr_in = head.entry.is_cr;
               if (head.entry.is_hex) begin
                  // saturate once another digit would overflow
                  if (size_acc_cur[COUNT_WIDTH-1 -: 4] != 4'd0) begin
                     size_acc_in = CNT_MAX;
                  end else begin
                     size_acc_in = {size_acc_cur[COUNT_WIDTH-5:0], head.entry.hex_digit};
                  end
               end
            end
         end
      endcase
   end

   // Length as shown on the result, saturated to the field width
   assign total_ext = EXT_W'(total_in);
   assign shown_len = (total_ext > EXT_W'({LEN_WIDTH{1'b1}})) ? '1
                                                            : total_ext[LEN_WIDTH-1:0];

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SIZE;
         seen_cr_ff  <= 1'b0;
         size_acc_ff <= '0;
         left_ff     <= '0;
         total_ff    <= '0;
      end else if (pop) begin
         phase_ff    <= phase_in;
         seen_cr_ff  <= seen_cr_in;
         size_acc_ff <= size_acc_in;
         left_ff     <= left_in;
         total_ff    <= total_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pop && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit && advance) begin
         rsp_data_ff     <= emit_last ? 8'd0 : head.entry.body_byte;
         rsp_has_data_ff <= !emit_last;
         rsp_is_last_ff  <= emit_last;
         rsp_len_ff      <= shown_len;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_byte      = rsp_data_ff;
   assign rsp_has_data       = rsp_has_data_ff;
   assign rsp_is_last        = rsp_is_last_ff;
   assign rsp_decoded_length = rsp_len_ff;

endmodule

// ----- hdl/http_chunked_body_decoder.sv -----
// Top level of the HTTP chunked transfer body decoder.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_valid / req_stall   req_body_byte, req_restart
//   rsp      out        rsp_valid / rsp_stall   rsp_data_byte, rsp_has_data,
//                                               rsp_is_last, rsp_decoded_length
//
// One byte per cycle is sustained while rsp_stall stays low; each transferred byte
// is written into the queue, then parsed from its head into the result register.
// The parser state machine handles one queued byte per cycle while the result
// register can advance; the queue (QUEUE_DEPTH entries) absorbs result-side stalls.
// Synchronous reset clears the queue, the parser and the result valid.
// req_stall rises only when the queue is full.
module http_chunked_body_decoder #(
   parameter int COUNT_WIDTH = chd_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_body_byte,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_data_byte,
   output logic                          rsp_has_data,
   output logic                          rsp_is_last,
   output logic [chd_pkg::LEN_WIDTH-1:0] rsp_decoded_length
);
   import chd_pkg::*;

   head_type head;
   logic     pop;

   chd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_body_byte (req_body_byte),
      .req_restart   (req_restart),
      .head          (head),
      .pop           (pop)
   );

   chd_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_has_data       (rsp_has_data),
      .rsp_is_last        (rsp_is_last),
      .rsp_decoded_length (rsp_decoded_length)
   );

endmodule

// ----- hdl/chd_checker.sv -----
// Port-level checks for the chunked body decoder, bound to the top level.
module chd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [7:0]                    rsp_data_byte,
   input logic                          rsp_has_data,
   input logic                          rsp_is_last,
   input logic [chd_pkg::LEN_WIDTH-1:0] rsp_decoded_length
);

   // Nothing is pending right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result valid or input stall after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_has_data) && $stable(rsp_is_last)
         && $stable(rsp_decoded_length))
      else $error("stalled result changed");

   // A result is either a payload byte or the end marker
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_has_data != rsp_is_last))
      else $error("result kind malformed");

   // The end marker carries no byte
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> rsp_data_byte == 8'd0)
      else $error("end marker with nonzero byte");

   // A payload byte always counts itself
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_data |-> rsp_decoded_length != '0)
      else $error("payload result with zero length");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_has_data       (rsp_has_data),
   .rsp_is_last        (rsp_is_last),
   .rsp_decoded_length (rsp_decoded_length)
);
